// ===== rtl/core/flash_erase_command_planner_macros.svh =====
// ----------------------------------------------------------------------------
// Erase command planner assertion macros
// Shared property macros for the planner modules. They expand to nothing
// when the code is taken in for synthesis.
// ----------------------------------------------------------------------------
`ifndef FLASH_ERASE_COMMAND_PLANNER_MACROS_SVH
`define FLASH_ERASE_COMMAND_PLANNER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define FECP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("erase planner check failed");

// Consequent must hold in the cycle after the antecedent.
`define FECP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("erase planner check failed");

`else

`define FECP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FECP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/fecp_pkg.sv =====
// ----------------------------------------------------------------------------
// Erase command planner package
// Field widths, erase granule sizes, register indexes and the types that
// pass between the front end, the request queue and the command walker.
// ----------------------------------------------------------------------------
package fecp_pkg;

    // Field widths of the request and command items.
    localparam int ADDR_W = 24;
    localparam int LEN_W  = 22;
    localparam int OPC_W  = 8;

    // Erase granules larger than a sector.
    localparam int BLOCK64_BYTES = 64 * 1024;
    localparam int BLOCK32_BYTES = 32 * 1024;
    localparam int BLOCK64_LSB   = $clog2(BLOCK64_BYTES);
    localparam int BLOCK32_LSB   = $clog2(BLOCK32_BYTES);
    localparam int STEP_W        = BLOCK64_LSB + 1;

    // Request limits.
    localparam int MAX_LENGTH  = 2 * 1024 * 1024;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Request queue between front end and walker (power of two deep).
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_OP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_OP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OP  = 2'd2;

    // Opcode values after reset.
    localparam logic [OPC_W-1:0] RST_SECTOR_OP = 8'h20;
    localparam logic [OPC_W-1:0] RST_HALF_OP   = 8'h52;
    localparam logic [OPC_W-1:0] RST_BLOCK_OP  = 8'hD8;

    // Kind of erase carried by a command item.
    typedef enum logic [1:0] {
        KIND_SECTOR = 2'd0,
        KIND_HALF   = 2'd1,
        KIND_BLOCK  = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    // Front end states.
    typedef enum logic [1:0] {
        F_IDLE,
        F_DIVIDE,
        F_PUSH
    } t_front_state;

    // Walker states.
    typedef enum logic {
        B_IDLE,
        B_WALK
    } t_back_state;

    // Opcode registers.
    typedef struct packed {
        logic [OPC_W-1:0] sector_op;
        logic [OPC_W-1:0] half_op;
        logic [OPC_W-1:0] block_op;
    } t_cfg;

    // A classified request, as held in the queue.
    typedef struct packed {
        logic [ADDR_W-1:0] start_address;
        logic [LEN_W-1:0]  length;
        logic              rejected;
    } t_plan;

    typedef struct packed {
        logic  valid;
        t_plan plan;
    } t_plan_req;

    // One erase command item.
    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [ADDR_W-1:0] address;
        t_kind             kind;
        logic              rejected;
        logic              last;
    } t_cmd;

endpackage

// ===== rtl/core/fecp_queue.sv =====
// ----------------------------------------------------------------------------
// Erase planner request queue
// Short flip-flop queue of classified requests between the front end and
// the command walker, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module fecp_queue import fecp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_plan_req i_push,
    output logic      o_push_ready,
    output t_plan_req o_head,
    input  logic      i_pop
);

    t_plan             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_fill;
    logic              push;
    logic              pop;

    // Handshakes on both ends.
    always_comb begin
        o_push_ready = (r_fill != (QPTR_W + 1)'(QUEUE_DEPTH));
        push         = i_push.valid && o_push_ready;
        pop          = i_pop && (r_fill != '0);
        o_head.valid = (r_fill != '0);
        o_head.plan  = r_slot[r_rd];
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_push.plan;
        end
    end

endmodule

// ===== rtl/core/fecp_front.sv =====
// ----------------------------------------------------------------------------
// Erase planner front end
// Accepts erase requests, rejects oversize lengths, drops empty ones and
// rounds the length up to whole sectors with a reciprocal multiplication.
// ----------------------------------------------------------------------------
`include "flash_erase_command_planner_macros.svh"

module fecp_front import fecp_pkg::*; #(
    parameter int SECTOR_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ADDR_W-1:0] i_start_address,
    input  logic [LEN_W-1:0]  i_erase_length,
    output t_plan_req         o_push,
    input  logic              i_push_ready
);

    // Sector count by multiplying with a scaled reciprocal; exact for any
    // dividend below 2**DIV_N.
    localparam int SEC_LOG2  = $clog2(SECTOR_BYTES);
    localparam int DIV_N     = LEN_W + 1;
    localparam int DIV_SHIFT = DIV_N + SEC_LOG2;
    localparam int RECIP_W   = DIV_N + 2;
    localparam int PROD_W    = DIV_N + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES));

    t_front_state       r_state;
    t_front_state       n_state;
    logic [ADDR_W-1:0]  r_start;
    logic [LEN_W-1:0]   r_len;
    logic               r_rej;
    logic [LEN_W-1:0]   r_quot;
    logic               accept;
    logic               oversize;
    logic [DIV_N-1:0]   padded;
    logic [PROD_W-1:0]  product;
    logic [LEN_W-1:0]   quot;
    logic [2*LEN_W-1:0] rounded;

    // Number of sectors needed, rounding any partial sector up.
    always_comb begin
        padded  = {1'b0, r_len} + DIV_N'(SECTOR_BYTES - 1);
        product = PROD_W'(padded) * PROD_W'(RECIP);
        quot    = LEN_W'(product >> DIV_SHIFT);
    end

    // Rounded length from the registered sector count.
    always_comb begin
        rounded = (2 * LEN_W)'(r_quot) * (2 * LEN_W)'(SECTOR_BYTES);
    end

    // Request classification and sequencing.
    always_comb begin
        o_in_stall = (r_state != F_IDLE);
        accept     = i_in_valid && (r_state == F_IDLE);
        oversize   = (i_erase_length > LEN_W'(MAX_LENGTH));
        n_state    = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    if (oversize) begin
                        n_state = F_PUSH;
                    end else if (i_erase_length != '0) begin
                        n_state = F_DIVIDE;
                    end
                end
            end
            F_DIVIDE: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (i_push_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase

        o_push.valid              = (r_state == F_PUSH);
        o_push.plan.start_address = r_start;
        o_push.plan.length        = r_rej ? '0 : rounded[LEN_W-1:0];
        o_push.plan.rejected      = r_rej;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request payload and sector count.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start <= i_start_address;
            r_len   <= i_erase_length;
            r_rej   <= oversize;
        end
        if (r_state == F_DIVIDE) begin
            r_quot <= quot;
        end
    end

    // The length must not move while the sector count is being formed.
    `FECP_ASSERT_NEXT(a_len_held, i_clk, i_rst_n, r_state == F_DIVIDE, $stable(r_len))
    // The divide state is always followed by the push state.
    `FECP_ASSERT_NEXT(a_divide_once, i_clk, i_rst_n, r_state == F_DIVIDE, r_state == F_PUSH)
    // Rounding never shortens a request.
    `FECP_ASSERT_IMPL(a_round_up, i_clk, i_rst_n, o_push.valid && !r_rej, o_push.plan.length >= r_len)
    // An accepted request that is queued for walking is never empty.
    `FECP_ASSERT_IMPL(a_push_nonzero, i_clk, i_rst_n, o_push.valid && !r_rej, o_push.plan.length != '0)

endmodule

// ===== rtl/core/fecp_back.sv =====
// ----------------------------------------------------------------------------
// Erase planner command walker
// Walks a queued request, forming one erase command per cycle unless the
// output stalls, of the largest aligned granule that fits. A pending stage
// holds each command until the next step shows whether it closes the run.
// ----------------------------------------------------------------------------
`include "flash_erase_command_planner_macros.svh"

module fecp_back import fecp_pkg::*; #(
    parameter int SECTOR_BYTES = 4096,
    parameter int ADDRESS_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_plan_req         i_head,
    output logic              o_pop,
    input  t_cfg              i_cfg,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [OPC_W-1:0]  o_command_opcode,
    output logic [ADDR_W-1:0] o_command_address,
    output logic [1:0]        o_erase_kind,
    output logic              o_rejected,
    output logic              o_last_command
);

    t_back_state             r_state;
    t_back_state             n_state;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [ADDRESS_BITS-1:0] n_addr;
    logic [LEN_W-1:0]        r_left;
    logic [LEN_W-1:0]        n_left;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_pend_valid;
    logic                    n_pend_valid;
    t_cmd                    r_pend;
    t_cmd                    n_pend;
    logic                    r_out_valid;
    logic                    n_out_valid;
    t_cmd                    r_out;
    t_cmd                    n_out;
    logic                    out_free;
    logic                    load_out;
    logic                    fit;
    logic                    fit_eff;
    logic [STEP_W-1:0]       step;
    t_cmd                    new_cmd;
    t_cmd                    out_cmd;

    // Pick the largest granule that fits at the current position.
    always_comb begin
        new_cmd.address  = ADDR_W'(r_addr);
        new_cmd.rejected = 1'b0;
        new_cmd.last     = 1'b0;
        fit              = 1'b1;
        priority if (r_left >= LEN_W'(BLOCK64_BYTES)
                     && r_addr[BLOCK64_LSB-1:0] == '0) begin
            new_cmd.opcode = i_cfg.block_op;
            new_cmd.kind   = KIND_BLOCK;
            step           = STEP_W'(BLOCK64_BYTES);
        end else if (r_left >= LEN_W'(BLOCK32_BYTES)
                     && r_addr[BLOCK32_LSB-1:0] == '0) begin
            new_cmd.opcode = i_cfg.half_op;
            new_cmd.kind   = KIND_HALF;
            step           = STEP_W'(BLOCK32_BYTES);
        end else if (r_left >= LEN_W'(SECTOR_BYTES)) begin
            new_cmd.opcode = i_cfg.sector_op;
            new_cmd.kind   = KIND_SECTOR;
            step           = STEP_W'(SECTOR_BYTES);
        end else begin
            new_cmd.opcode = i_cfg.sector_op;
            new_cmd.kind   = KIND_SECTOR;
            step           = '0;
            fit            = 1'b0;
        end
        fit_eff = fit && (r_count != CNT_W'(MAX_RESULTS));
    end

    // Walker sequencing and output register loading.
    always_comb begin
        out_free     = !r_out_valid || !i_out_stall;
        load_out     = 1'b0;
        o_pop        = 1'b0;
        n_state      = r_state;
        n_addr       = r_addr;
        n_left       = r_left;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        out_cmd      = r_pend;

        unique case (r_state)
            B_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.plan.rejected) begin
                        // A rejected request gives a single closing item.
                        if (out_free) begin
                            o_pop            = 1'b1;
                            load_out         = 1'b1;
                            out_cmd.opcode   = '0;
                            out_cmd.address  = i_head.plan.start_address;
                            out_cmd.kind     = KIND_REJECT;
                            out_cmd.rejected = 1'b1;
                            out_cmd.last     = 1'b1;
                        end
                    end else begin
                        o_pop        = 1'b1;
                        n_state      = B_WALK;
                        n_addr       = ADDRESS_BITS'(i_head.plan.start_address);
                        n_left       = i_head.plan.length;
                        n_count      = '0;
                        n_pend_valid = 1'b0;
                    end
                end
            end
            B_WALK: begin
                if (fit_eff) begin
                    // Another command follows, so the pending one is not last.
                    if (!r_pend_valid || out_free) begin
                        load_out     = r_pend_valid;
                        out_cmd.last = 1'b0;
                        n_pend       = new_cmd;
                        n_pend_valid = 1'b1;
                        n_addr       = r_addr + ADDRESS_BITS'(step);
                        n_left       = r_left - LEN_W'(step);
                        n_count      = r_count + 1'b1;
                    end
                end else if (!r_pend_valid) begin
                    n_state = B_IDLE;
                end else if (out_free) begin
                    // Nothing more fits: the pending command closes the run.
                    load_out     = 1'b1;
                    out_cmd.last = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
        n_out = load_out ? out_cmd : r_out;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Walk position and command payloads.
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_left <= n_left;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid       = r_out_valid;
    assign o_command_opcode  = r_out.opcode;
    assign o_command_address = r_out.address;
    assign o_erase_kind      = r_out.kind;
    assign o_rejected        = r_out.rejected;
    assign o_last_command    = r_out.last;

    // A run never forms more commands than the cap.
    `FECP_ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, r_state == B_WALK, r_count <= CNT_W'(MAX_RESULTS))
    // A pending command only exists while a run is being walked.
    `FECP_ASSERT_IMPL(a_pend_walk, i_clk, i_rst_n, r_pend_valid, r_state == B_WALK)
    // A rejected item is always a closing item of the reject kind.
    `FECP_ASSERT_IMPL(a_reject_last, i_clk, i_rst_n, r_out_valid && r_out.rejected, r_out.last && r_out.kind == KIND_REJECT)
    // A 64 KiB block erase is only issued on a 64 KiB boundary.
    `FECP_ASSERT_IMPL(a_block_aligned, i_clk, i_rst_n, r_out_valid && r_out.kind == KIND_BLOCK, r_out.address[BLOCK64_LSB-1:0] == '0)

endmodule

// ===== rtl/core/flash_erase_command_planner.sv =====
// A request is accepted, its sector count is formed in the next cycle and it is queued in the
// one after if the queue has room; the walker then turns it into erase commands.
// A rejected request skips the sector count and is queued as a single closing item.
// The walker forms one command per cycle while the output is not stalled, up to 64 per request.
// The front end stalls until its request is queued; a two-entry queue lets it run ahead.
// Reset is synchronous, active low: control state clears and the opcodes return to defaults.
// ----------------------------------------------------------------------------
// Flash erase command planner
// Turns an erase request (start address, length) into a run of sector,
// 32 KiB and 64 KiB erase commands, with programmable opcodes.
// ----------------------------------------------------------------------------
module flash_erase_command_planner import fecp_pkg::*; #(
    parameter int SECTOR_BYTES = 4096,
    parameter int ADDRESS_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [OPC_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ADDR_W-1:0]    i_start_address,
    input  logic [LEN_W-1:0]     i_erase_length,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OPC_W-1:0]     o_command_opcode,
    output logic [ADDR_W-1:0]    o_command_address,
    output logic [1:0]           o_erase_kind,
    output logic                 o_rejected,
    output logic                 o_last_command
);

    t_cfg      r_cfg;
    t_plan_req push_req;
    logic      push_ready;
    t_plan_req head;
    logic      pop;

    // Opcode registers; writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sector_op <= RST_SECTOR_OP;
            r_cfg.half_op   <= RST_HALF_OP;
            r_cfg.block_op  <= RST_BLOCK_OP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SECTOR_OP: r_cfg.sector_op <= i_cfg_data;
                CFG_HALF_OP:   r_cfg.half_op   <= i_cfg_data;
                CFG_BLOCK_OP:  r_cfg.block_op  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Request intake and length rounding.
    fecp_front #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_address (i_start_address),
        .i_erase_length  (i_erase_length),
        .o_push          (push_req),
        .i_push_ready    (push_ready)
    );

    // Classified requests waiting for the walker.
    fecp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_req),
        .o_push_ready (push_ready),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Command generation.
    fecp_back #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .o_pop             (pop),
        .i_cfg             (r_cfg),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_command_opcode  (o_command_opcode),
        .o_command_address (o_command_address),
        .o_erase_kind      (o_erase_kind),
        .o_rejected        (o_rejected),
        .o_last_command    (o_last_command)
    );

endmodule
